@@ design/blackbody_color_from_temperature_macros.svh @@
// Assertion macros for the blackbody color pipeline.
// Used by blackbody_color_from_temperature.sv; expects clk and arst_n in scope.
`ifndef BLACKBODY_COLOR_FROM_TEMPERATURE_MACROS_SVH
`define BLACKBODY_COLOR_FROM_TEMPERATURE_MACROS_SVH

// pre implies post in the same cycle
`define BBC_ASSERT_IMP(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) else $error(msg);

// pre implies post in the next cycle
`define BBC_ASSERT_NXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) else $error(msg);

`endif

@@ design/bbc_pkg.sv @@
// Shared constants for the blackbody color pipeline: locus polynomial
// coefficients, XYZ to linear RGB matrix, fixed-point widths. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package bbc_pkg;

	localparam int unsigned FRAC_BITS_DEF = 16;
	localparam int unsigned WORK_BITS     = 24;
	localparam int unsigned OUT_W         = 20;
	localparam longint unsigned MAT_SCALE = 64'd10000000;

	localparam logic [63:0] C_NU0 = 64'd860117757000000;
	localparam logic [63:0] C_NU1 = 64'd154118254000;
	localparam logic [63:0] C_NU2 = 64'd128641212;
	localparam logic [63:0] C_DU0 = 64'd1000000000000000;
	localparam logic [63:0] C_DU1 = 64'd842420235000;
	localparam logic [63:0] C_DU2 = 64'd708145163;
	localparam logic [63:0] C_NV0 = 64'd3173987260000000;
	localparam logic [63:0] C_NV1 = 64'd422806245000;
	localparam logic [63:0] C_NV2 = 64'd420481691;
	localparam logic [63:0] C_DV0 = 64'd10000000000000000;
	localparam logic [63:0] C_DV1 = 64'd289741816000;
	localparam logic [63:0] C_DV2 = 64'd1614560530;

	typedef logic signed [25:0] mcoef_t;

	localparam mcoef_t RGB_MAT [3][3] = '{
		'{ 26'sd32404542, -26'sd15371385, -26'sd4985314 },
		'{ -26'sd9692660,  26'sd18760108,  26'sd415560  },
		'{ 26'sd556434,   -26'sd2040259,   26'sd10572252 }
	};

endpackage

`default_nettype wire

@@ design/bbc_div.sv @@
// Pipelined restoring divider, BPS quotient bits per stage, side data carried along.
// Starting remainder must be below the divisor. No package dependency.
`timescale 1ns / 1ps
`default_nettype none

module bbc_div #(
	parameter int unsigned DW  = 33,
	parameter int unsigned QW  = 30,
	parameter int unsigned SW  = 1,
	parameter int unsigned BPS = 2
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          en,
	input  wire logic          in_vld,
	input  wire logic [DW-1:0] in_rem,
	input  wire logic [QW-1:0] in_low,
	input  wire logic [DW-1:0] in_den,
	input  wire logic [SW-1:0] in_side,
	output logic               out_vld,
	output logic      [QW-1:0] out_quo,
	output logic      [SW-1:0] out_side
);

	localparam int unsigned NS = QW / BPS;

	logic          vld_s  [NS+1];
	logic [DW-1:0] rem_s  [NS+1];
	logic [QW-1:0] low_s  [NS+1];
	logic [DW-1:0] den_s  [NS+1];
	logic [SW-1:0] side_s [NS+1];

	assign vld_s[0]  = in_vld;
	assign rem_s[0]  = in_rem;
	assign low_s[0]  = in_low;
	assign den_s[0]  = in_den;
	assign side_s[0] = in_side;

	for (genvar g = 0; g < NS; g++) begin : g_stage
		logic [DW-1:0] r_c [BPS+1];
		logic [QW-1:0] l_c [BPS+1];

		always_comb begin
			logic [DW:0] tr;
			r_c[0] = rem_s[g];
			l_c[0] = low_s[g];
			for (int j = 0; j < BPS; j++) begin
				tr = {r_c[j], l_c[j][QW-1]};
				if (tr >= {1'b0, den_s[g]}) begin
					tr = tr - {1'b0, den_s[g]};
					l_c[j+1] = {l_c[j][QW-2:0], 1'b1};
				end else begin
					l_c[j+1] = {l_c[j][QW-2:0], 1'b0};
				end
				r_c[j+1] = tr[DW-1:0];
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[g+1] <= 1'b0;
			end else if (en) begin
				vld_s[g+1] <= vld_s[g];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[g+1]  <= r_c[BPS];
				low_s[g+1]  <= l_c[BPS];
				den_s[g+1]  <= den_s[g];
				side_s[g+1] <= side_s[g];
			end
		end
	end

	assign out_vld  = vld_s[NS];
	assign out_quo  = low_s[NS];
	assign out_side = side_s[NS];

endmodule

`default_nettype wire

@@ design/blackbody_color_from_temperature.sv @@
// Top level: temperature and luminance to linear RGB through locus, XYZ and matrix.
// Depends on bbc_pkg, bbc_div and the assertion macro header.
//
//  channel | signals                                  | direction
//  input   | in_valid, in_stall, temperature_kelvin,  | in (in_stall out)
//          | luminance                                |
//  output  | out_valid, out_stall, red, green, blue   | out (out_stall in)
//
// One transfer per cycle while the output is not stalled; the divider chains have
// 16 stages for the locus ratios, 15 for X and Z and 10 for the final scaling.
// Reset clears all valid bits; payload registers are not reset.
// A stalled output freezes the whole pipeline; in_stall is high exactly then.
`timescale 1ns / 1ps
`default_nettype none
`include "blackbody_color_from_temperature_macros.svh"

module blackbody_color_from_temperature
	import bbc_pkg::*;
#(
	parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic        [15:0] temperature_kelvin,
	input  wire logic        [15:0] luminance,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic signed [OUT_W-1:0] red,
	output logic signed [OUT_W-1:0] green,
	output logic signed [OUT_W-1:0] blue
);

	localparam int unsigned SHIFT = WORK_BITS - FRAC_BITS;
	localparam logic [58:0] HALF  = 59'(MAT_SCALE / 2) << SHIFT;
	localparam logic [58:0] LIM   = 59'(MAT_SCALE) << (OUT_W - 1);
	localparam logic [36:0] B_BASE = 37'h4_0000_0000;

	logic en;
	logic out_vld_q;

	assign en        = !out_vld_q || !out_stall;
	assign in_stall  = !en;
	assign out_valid = out_vld_q;

	// locus polynomials
	logic        vld_s1, vld_s2, vld_s3;
	logic [15:0] t_s1, lum_s1, lum_s2, lum_s3;
	logic [31:0] tt_s1;
	logic [63:0] pnu1_s2, pnu2_s2, pdu1_s2, pdu2_s2, pnv1_s2, pnv2_s2, pdv1_s2, pdv2_s2;
	logic [63:0] nu_s3, du_s3, nv_s3, dv_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			t_s1    <= temperature_kelvin;
			lum_s1  <= luminance;
			tt_s1   <= 32'(temperature_kelvin * temperature_kelvin);
			lum_s2  <= lum_s1;
			pnu1_s2 <= C_NU1 * 64'(t_s1);
			pnu2_s2 <= C_NU2 * 64'(tt_s1);
			pdu1_s2 <= C_DU1 * 64'(t_s1);
			pdu2_s2 <= C_DU2 * 64'(tt_s1);
			pnv1_s2 <= C_NV1 * 64'(t_s1);
			pnv2_s2 <= C_NV2 * 64'(tt_s1);
			pdv1_s2 <= C_DV1 * 64'(t_s1);
			pdv2_s2 <= C_DV2 * 64'(tt_s1);
			lum_s3  <= lum_s2;
			nu_s3   <= C_NU0 + pnu1_s2 + pnu2_s2;
			du_s3   <= C_DU0 + pdu1_s2 + pdu2_s2;
			nv_s3   <= C_NV0 + pnv1_s2 + pnv2_s2;
			dv_s3   <= C_DV0 + pdv2_s2 - pdv1_s2;
		end
	end

	// u and v as Q0.32
	logic        u_vld, v_vld;
	logic [31:0] u_q, v_q;
	logic [15:0] u_lum, v_lum;

	bbc_div #(.DW(63), .QW(32), .SW(16), .BPS(2)) u_div_u (
		.clk, .arst_n, .en,
		.in_vld(vld_s3), .in_rem(nu_s3[62:0]), .in_low(32'd0), .in_den(du_s3[62:0]),
		.in_side(lum_s3),
		.out_vld(u_vld), .out_quo(u_q), .out_side(u_lum)
	);

	bbc_div #(.DW(63), .QW(32), .SW(16), .BPS(2)) u_div_v (
		.clk, .arst_n, .en,
		.in_vld(vld_s3), .in_rem(nv_s3[62:0]), .in_low(32'd0), .in_den(dv_s3[62:0]),
		.in_side(lum_s3),
		.out_vld(v_vld), .out_quo(v_q), .out_side(v_lum)
	);

	// X and Z numerators
	logic        vld_sa, vld_sb, vld_sc;
	logic [33:0] a_sa;
	logic [35:0] bmag_sa;
	logic        negz_sa, negz_sb, negz_sc;
	logic [31:0] v_sa, v_sb, v_sc;
	logic [15:0] lum_sa, lum_sb, lum_sc;
	logic [49:0] mx_sb;
	logic [51:0] mz_sb;
	logic [58:0] nx_sc;
	logic [60:0] nz_sc;
	logic [36:0] b_c;

	assign b_c = B_BASE - {5'd0, u_q} - ({5'd0, v_q} * 37'd10);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_sa <= 1'b0;
			vld_sb <= 1'b0;
			vld_sc <= 1'b0;
		end else if (en) begin
			vld_sa <= u_vld && v_vld;
			vld_sb <= vld_sa;
			vld_sc <= vld_sb;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a_sa    <= 34'({2'd0, u_q} * 34'd3);
			negz_sa <= b_c[36];
			bmag_sa <= b_c[36] ? 36'(-b_c) : b_c[35:0];
			v_sa    <= v_q;
			lum_sa  <= u_lum;
			mx_sb   <= 50'(lum_sa) * 50'(a_sa);
			mz_sb   <= 52'(lum_sa) * 52'(bmag_sa);
			negz_sb <= negz_sa;
			v_sb    <= v_sa;
			lum_sb  <= lum_sa;
			nx_sc   <= {1'b0, mx_sb, 8'd0} + 59'(v_sb);
			nz_sc   <= {1'b0, mz_sb, 8'd0} + 61'(v_sb);
			negz_sc <= negz_sb;
			v_sc    <= v_sb;
			lum_sc  <= lum_sb;
		end
	end

	// X and Z in Q.24, rounded
	logic        x_vld, z_vld;
	logic [29:0] qx, qz;
	logic [16:0] x_side, z_side;

	bbc_div #(.DW(33), .QW(30), .SW(17), .BPS(2)) u_div_x (
		.clk, .arst_n, .en,
		.in_vld(vld_sc), .in_rem({4'd0, nx_sc[58:30]}), .in_low(nx_sc[29:0]),
		.in_den({v_sc, 1'b0}), .in_side({negz_sc, lum_sc}),
		.out_vld(x_vld), .out_quo(qx), .out_side(x_side)
	);

	bbc_div #(.DW(33), .QW(30), .SW(17), .BPS(2)) u_div_z (
		.clk, .arst_n, .en,
		.in_vld(vld_sc), .in_rem({2'd0, nz_sc[60:30]}), .in_low(nz_sc[29:0]),
		.in_den({v_sc, 1'b0}), .in_side({negz_sc, lum_sc}),
		.out_vld(z_vld), .out_quo(qz), .out_side(z_side)
	);

	// matrix
	logic               vld_sd, vld_se, vld_sf, vld_sg, vld_sh;
	logic signed [30:0] xyz_sd  [3];
	logic signed [56:0] prod_se [3][3];
	logic signed [58:0] sum_sf  [3];
	logic        [57:0] mag_sg  [3];
	logic               neg_sg  [3];
	logic        [58:0] w_sh    [3];
	logic               neg_sh  [3];
	logic               ovf_sh  [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_sd <= 1'b0;
			vld_se <= 1'b0;
			vld_sf <= 1'b0;
			vld_sg <= 1'b0;
			vld_sh <= 1'b0;
		end else if (en) begin
			vld_sd <= x_vld && z_vld;
			vld_se <= vld_sd;
			vld_sf <= vld_se;
			vld_sg <= vld_sf;
			vld_sh <= vld_sg;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			xyz_sd[0] <= $signed({1'b0, qx});
			xyz_sd[1] <= $signed({7'd0, x_side[15:0], 8'd0});
			xyz_sd[2] <= z_side[16] ? -$signed({1'b0, qz}) : $signed({1'b0, qz});
			for (int c = 0; c < 3; c++) begin
				for (int k = 0; k < 3; k++) begin
					prod_se[c][k] <= 57'(xyz_sd[k]) * 57'(RGB_MAT[c][k]);
				end
				sum_sf[c] <= 59'(prod_se[c][0]) + 59'(prod_se[c][1]) + 59'(prod_se[c][2]);
				neg_sg[c] <= sum_sf[c][58];
				mag_sg[c] <= 58'(sum_sf[c][58] ? -sum_sf[c] : sum_sf[c]);
				w_sh[c]   <= (59'(mag_sg[c]) + HALF) >> SHIFT;
				ovf_sh[c] <= ((59'(mag_sg[c]) + HALF) >> SHIFT) >= LIM;
				neg_sh[c] <= neg_sg[c];
			end
		end
	end

	// final scaling and saturation
	logic                    ch_vld  [3];
	logic        [OUT_W-1:0] ch_q    [3];
	logic        [1:0]       ch_side [3];
	logic signed [OUT_W-1:0] res_q   [3];

	for (genvar c = 0; c < 3; c++) begin : g_ch
		bbc_div #(.DW(24), .QW(OUT_W), .SW(2), .BPS(2)) u_div_ch (
			.clk, .arst_n, .en,
			.in_vld(vld_sh),
			.in_rem(ovf_sh[c] ? 24'd0 : 24'(w_sh[c] >> OUT_W)),
			.in_low(w_sh[c][OUT_W-1:0]),
			.in_den(24'(MAT_SCALE)),
			.in_side({neg_sh[c], ovf_sh[c]}),
			.out_vld(ch_vld[c]), .out_quo(ch_q[c]), .out_side(ch_side[c])
		);

		always_ff @(posedge clk) begin
			if (en) begin
				if (ch_side[c][0]) begin
					res_q[c] <= ch_side[c][1] ? {1'b1, {(OUT_W-1){1'b0}}}
						: {1'b0, {(OUT_W-1){1'b1}}};
				end else begin
					res_q[c] <= ch_side[c][1] ? $signed(-ch_q[c]) : $signed(ch_q[c]);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (en) begin
			out_vld_q <= ch_vld[0] && ch_vld[1] && ch_vld[2];
		end
	end

	assign red   = res_q[0];
	assign green = res_q[1];
	assign blue  = res_q[2];

	`BBC_ASSERT_IMP(a_uv_lanes, u_vld || v_vld, u_vld && v_vld && (u_lum == v_lum), "u/v lanes out of step")
	`BBC_ASSERT_IMP(a_xz_lanes, x_vld || z_vld, x_vld && z_vld && (x_side == z_side), "x/z lanes out of step")
	`BBC_ASSERT_IMP(a_ch_lanes, ch_vld[0] || ch_vld[1] || ch_vld[2], ch_vld[0] && ch_vld[1] && ch_vld[2], "channel lanes out of step")
	`BBC_ASSERT_IMP(a_ch_range, ch_vld[0] && !ch_side[0][0], !ch_q[0][OUT_W-1], "red quotient beyond range")
	`BBC_ASSERT_NXT(a_freeze, !en, $stable(vld_sh) && $stable(vld_sc), "pipeline moved while stalled")

endmodule

`default_nettype wire

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps
// Regression bench for blackbody_color_from_temperature: table-driven directed
// transfers, then random traffic, checked against an in-bench fixed-point locus model.
// Depends on bbc_pkg and the block itself.

module tb_top;
	import bbc_pkg::*;

	localparam int FB = 16;
	localparam longint OMAX = 524287;
	localparam longint OMIN = -524288;

	typedef struct {
		logic signed [19:0] r;
		logic signed [19:0] g;
		logic signed [19:0] b;
	} rgb_t;

	typedef struct {
		logic [15:0] kelvin;
		logic [15:0] lum;
		bit          known;
		rgb_t        rgb;
	} stim_row_t;

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_stall;
	logic [15:0] temperature_kelvin = 0;
	logic [15:0] luminance = 0;
	logic out_valid;
	logic out_stall = 0;
	logic signed [19:0] red, green, blue;

	rgb_t pending_rgb[$];
	rgb_t last_rgb;
	int errors = 0;
	int send_gap = 0;
	int recv_gap = 0;

	always #4 clk = ~clk;

	blackbody_color_from_temperature dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.temperature_kelvin(temperature_kelvin), .luminance(luminance),
		.out_valid(out_valid), .out_stall(out_stall),
		.red(red), .green(green), .blue(blue)
	);

	function automatic logic [63:0] ratio_q32(logic [63:0] n, logic [63:0] d);
		logic [127:0] q;
		if (d == 0 || n >= d)
			return 64'hFFFFFFFF;
		q = {n, 32'd0} / d;
		return q[63:0];
	endfunction

	function automatic longint round_div(longint n, longint d);
		longint m;
		m = (n < 0) ? -n : n;
		m = (m + d / 2) / d;
		return (n < 0) ? -m : m;
	endfunction

	function automatic rgb_t locus_rgb(logic [15:0] kelvin, logic [15:0] lum);
		logic [63:0] t, tt, nu, du, nv, dv, u, v;
		longint a, bz, den, x, y, z, s;
		longint ch[3];
		rgb_t res;
		t = kelvin;
		tt = t * t;
		nu = C_NU0 + C_NU1 * t + C_NU2 * tt;
		du = C_DU0 + C_DU1 * t + C_DU2 * tt;
		nv = C_NV0 + C_NV1 * t + C_NV2 * tt;
		dv = (C_DV0 + C_DV2 * tt) - C_DV1 * t;
		u = ratio_q32(nu, du);
		v = ratio_q32(nv, dv);
		if (v == 0)
			v = 1;
		a = 3 * longint'(u);
		bz = (longint'(4) <<< 32) - longint'(u) - 10 * longint'(v);
		den = 2 * longint'(v);
		x = round_div(longint'(lum) * a * 256, den);
		z = round_div(longint'(lum) * bz * 256, den);
		y = longint'(lum) * 256;
		for (int c = 0; c < 3; c++) begin
			s = longint'(RGB_MAT[c][0]) * x + longint'(RGB_MAT[c][1]) * y
				+ longint'(RGB_MAT[c][2]) * z;
			s = round_div(s, longint'(MAT_SCALE) <<< (WORK_BITS - FB));
			if (s > OMAX)
				s = OMAX;
			if (s < OMIN)
				s = OMIN;
			ch[c] = s;
		end
		res.r = ch[0][19:0];
		res.g = ch[1][19:0];
		res.b = ch[2][19:0];
		return res;
	endfunction

	task automatic send_color(logic [15:0] kelvin, logic [15:0] lum, int idle_pct);
		while (idle_pct > 0 && $urandom_range(99, 0) < idle_pct) begin
			in_valid <= 0;
			@(posedge clk);
		end
		in_valid <= 1;
		temperature_kelvin <= kelvin;
		luminance <= lum;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	task automatic drain_wait;
		in_valid <= 0;
		@(posedge clk);
		while (pending_rgb.size() != 0)
			@(posedge clk);
	endtask

	// log expected values at acceptance
	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall)
			pending_rgb.push_back(locus_rgb(temperature_kelvin, luminance));
	end

	always @(posedge clk) begin
		rgb_t exp_rgb;
		if (arst_n && out_valid && !out_stall) begin
			last_rgb.r = red;
			last_rgb.g = green;
			last_rgb.b = blue;
			if (pending_rgb.size() == 0) begin
				$display("%0t: unexpected transfer r=%0d g=%0d b=%0d", $time, red, green, blue);
				errors++;
			end else begin
				exp_rgb = pending_rgb.pop_front();
				if (red !== exp_rgb.r) begin
					$display("%0t: red expected %0d actual %0d", $time, exp_rgb.r, red);
					errors++;
				end
				if (green !== exp_rgb.g) begin
					$display("%0t: green expected %0d actual %0d", $time, exp_rgb.g, green);
					errors++;
				end
				if (blue !== exp_rgb.b) begin
					$display("%0t: blue expected %0d actual %0d", $time, exp_rgb.b, blue);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		out_stall <= (recv_gap > 0) && ($urandom_range(99, 0) < recv_gap);
	end

	initial begin
		stim_row_t rows[$];
		stim_row_t row;
		logic [15:0] kv;
		rows.push_back('{16'd6500, 16'd0, 1, '{20'sd0, 20'sd0, 20'sd0}});
		rows.push_back('{16'd0, 16'd0, 1, '{20'sd0, 20'sd0, 20'sd0}});
		rows.push_back('{16'hFFFF, 16'd0, 1, '{20'sd0, 20'sd0, 20'sd0}});
		rows.push_back('{16'd0, 16'hFFFF, 0, '{20'sd0, 20'sd0, 20'sd0}});
		rows.push_back('{16'hFFFF, 16'hFFFF, 0, '{20'sd0, 20'sd0, 20'sd0}});
		rows.push_back('{16'd1000, 16'hFFFF, 0, '{20'sd0, 20'sd0, 20'sd0}});
		rows.push_back('{16'd1000, 16'd1, 0, '{20'sd0, 20'sd0, 20'sd0}});
		rows.push_back('{16'd15000, 16'hFFFF, 0, '{20'sd0, 20'sd0, 20'sd0}});
		rows.push_back('{16'd40000, 16'h8000, 0, '{20'sd0, 20'sd0, 20'sd0}});
		rows.push_back('{16'd6504, 16'h8000, 0, '{20'sd0, 20'sd0, 20'sd0}});
		rows.push_back('{16'd2700, 16'h5555, 0, '{20'sd0, 20'sd0, 20'sd0}});
		rows.push_back('{16'd500, 16'hAAAA, 0, '{20'sd0, 20'sd0, 20'sd0}});
		rows.push_back('{16'd1, 16'h7FFF, 0, '{20'sd0, 20'sd0, 20'sd0}});
		rows.push_back('{16'd25000, 16'd1, 0, '{20'sd0, 20'sd0, 20'sd0}});

		repeat (9) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		foreach (rows[i]) begin
			row = rows[i];
			if (row.known) begin
				drain_wait();
				send_color(row.kelvin, row.lum, 0);
				drain_wait();
				if (last_rgb.r !== row.rgb.r || last_rgb.g !== row.rgb.g
					|| last_rgb.b !== row.rgb.b) begin
					$display("%0t: row %0d expected %0d %0d %0d actual %0d %0d %0d", $time, i,
						row.rgb.r, row.rgb.g, row.rgb.b, last_rgb.r, last_rgb.g, last_rgb.b);
					errors++;
				end
			end else begin
				send_color(row.kelvin, row.lum, 0);
			end
		end

		for (int phase = 0; phase < 3; phase++) begin
			send_gap = (phase == 0) ? 32 : (phase == 1) ? 72 : 0;
			recv_gap = (phase == 0) ? 72 : (phase == 1) ? 32 : 0;
			for (int n = 0; n < 600; n++) begin
				case ($urandom_range(3, 0))
					0: kv = 16'($urandom_range(15000, 1000));
					1: kv = 16'($urandom_range(65535, 0));
					default: kv = 16'($urandom_range(12000, 1500));
				endcase
				send_color(kv, 16'($urandom_range(65535, 0)), send_gap);
				if (n == 300)
					drain_wait();
			end
		end
		recv_gap = 0;
		drain_wait();
		repeat (80) @(posedge clk);
		if (errors == 0)
			$display("blackbody_color_from_temperature regression: pass");
		else
			$display("blackbody_color_from_temperature regression: fail");
		$finish;
	end

	initial begin
		#4000000;
		$display("blackbody_color_from_temperature regression: fail");
		$finish;
	end
endmodule

@@ blackbody_color_from_temperature.f @@
+incdir+design
design/bbc_pkg.sv
design/bbc_div.sv
design/blackbody_color_from_temperature.sv
bench/tb_top.sv
